### rtl/bab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_pkg: shared types and constants of the bitmap block allocator
// Map geometry, request/response beats, command and status codes, the
// sequencer states and the reset pattern of a map row.
// ----------------------------------------------------------------------------
package bab_pkg;

    localparam int NUM_BLOCKS      = 4096;
    localparam int NUM_INODES      = 256;
    localparam int RESERVED_BLOCKS = 26;
    localparam int SCAN_BITS       = 32;

    localparam int IDX_W    = 12;
    localparam int BIT_W    = $clog2(SCAN_BITS);
    localparam int BLK_ROWS = (NUM_BLOCKS + SCAN_BITS - 1) / SCAN_BITS;
    localparam int INO_ROWS = (NUM_INODES + SCAN_BITS - 1) / SCAN_BITS;
    localparam int ROWS     = BLK_ROWS + INO_ROWS;
    localparam int ADDR_W   = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        CMD_FIND    = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_ALLOC   = 2'd3
    } bab_cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_RANGE     = 2'd2
    } bab_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_UPDATE
    } bab_state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic             map_select;
        logic [IDX_W-1:0] index;
    } bab_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] result_index;
        logic             was_free;
    } bab_rsp_t;

    // Free pattern of a row that was never written since reset.
    function automatic logic [SCAN_BITS-1:0] row_reset(input logic [ADDR_W-1:0] row);
        logic [SCAN_BITS-1:0] w;
        int                   e;
        w = '0;
        for (int b = 0; b < SCAN_BITS; b++)
        begin
            if (int'(row) < BLK_ROWS)
            begin
                e    = int'(row) * SCAN_BITS + b;
                w[b] = (e >= RESERVED_BLOCKS) && (e < NUM_BLOCKS);
            end
            else
            begin
                e    = (int'(row) - BLK_ROWS) * SCAN_BITS + b;
                w[b] = (e != 0) && (e < NUM_INODES);
            end
        end
        return w;
    endfunction

endpackage

### rtl/bab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_ram: free-map word store
// Both maps, one row of SCAN_BITS free bits per word, block rows first.
// A row valid bit, cleared by reset, makes an unwritten row read as its
// reset pattern. Read data is registered.
// ----------------------------------------------------------------------------
module bab_ram
    import bab_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [SCAN_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [SCAN_BITS-1:0] rd_data
);

    logic [SCAN_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]      vld_reg;
    logic [SCAN_BITS-1:0] mem_q_reg;
    logic [SCAN_BITS-1:0] rst_q_reg;
    logic                 vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
        rst_q_reg <= row_reset(rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : rst_q_reg;

endmodule

### rtl/bab_ffs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_ffs: find-first-free unit
// Returns the position of the lowest set bit of one map row.
// ----------------------------------------------------------------------------
module bab_ffs
    import bab_pkg::*;
(
    input  logic [SCAN_BITS-1:0] word,
    output logic                 found,
    output logic [BIT_W-1:0]     pos
);

    always_comb
    begin
        pos = '0;
        // walk down so the lowest set bit wins
        for (int b = SCAN_BITS - 1; b >= 0; b--)
        begin
            if (word[b])
            begin
                pos = BIT_W'(b);
            end
        end
    end

    assign found = |word;

endmodule

### rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator: two-map free-bit allocator
// Block and inode free maps with find, allocate, mark-used and release.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; exactly one
// response beat follows, marked by done for a single cycle, and it cannot be
// held off. Find and allocate scan the named map one 32-bit row per cycle
// through a single row store and one find-first unit, 128 rows on the block
// map and 8 on the inode map, ending early at the first row with a free bit.
// Mark-used and release take a read-modify-write of one row, read in S_FETCH
// and written back in S_UPDATE; an out-of-range index is answered the cycle
// after the request. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
    import bab_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bab_req_t request,
    output logic     done,
    output bab_rsp_t response
);

    bab_state_t           state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic                 sel_reg, sel_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    drow_reg, drow_next;
    logic                 pend_reg, pend_next;
    bab_rsp_t             rsp_reg, rsp_next;
    logic                 done_reg, done_next;

    logic                 accept;
    logic                 req_range_err;
    logic                 req_is_scan;
    logic [ADDR_W-1:0]    base;
    logic [ADDR_W-1:0]    last_row;
    logic [ADDR_W-1:0]    idx_row;
    logic [BIT_W-1:0]     idx_bit;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [SCAN_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [SCAN_BITS-1:0] rd_data;
    logic                 ffs_found;
    logic [BIT_W-1:0]     ffs_pos;
    logic [SCAN_BITS-1:0] bit_mask;

    bab_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bab_ffs u_ffs (
        .word  (rd_data),
        .found (ffs_found),
        .pos   (ffs_pos)
    );

    assign accept        = start && !busy;
    assign req_is_scan   = (request.command == CMD_FIND) || (request.command == CMD_ALLOC);
    assign req_range_err = request.map_select ? (32'(request.index) >= 32'(NUM_INODES))
                                              : (32'(request.index) >= 32'(NUM_BLOCKS));

    assign base     = sel_reg ? ADDR_W'(BLK_ROWS) : '0;
    assign last_row = sel_reg ? ADDR_W'(INO_ROWS - 1) : ADDR_W'(BLK_ROWS - 1);
    assign idx_row  = base + ADDR_W'(idx_reg[IDX_W-1:BIT_W]);
    assign idx_bit  = idx_reg[BIT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_is_scan)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (!req_range_err)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && (ffs_found || (drow_reg == last_row)))
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_next  = cmd_reg;
        sel_next  = sel_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        drow_next = drow_reg;
        pend_next = 1'b0;
        rsp_next  = rsp_reg;
        done_next = 1'b0;
        busy      = 1'b1;
        wr_en     = 1'b0;
        wr_addr   = drow_reg + base;
        bit_mask  = '0;
        wr_data   = rd_data;
        rd_addr   = base + cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    cmd_next = request.command;
                    sel_next = request.map_select;
                    idx_next = request.index;
                    cnt_next = '0;
                    if (!req_is_scan && req_range_err)
                    begin
                        rsp_next.status       = ST_RANGE;
                        rsp_next.result_index = request.index;
                        rsp_next.was_free     = 1'b0;
                        done_next             = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // keep a read in flight each cycle until the last row
                if (cnt_reg <= last_row)
                begin
                    pend_next = 1'b1;
                    drow_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (ffs_found)
                    begin
                        rsp_next.status       = ST_OK;
                        rsp_next.result_index =
                            IDX_W'((int'(drow_reg) << BIT_W) | int'(ffs_pos));
                        rsp_next.was_free     = 1'b1;
                        done_next             = 1'b1;
                        bit_mask[ffs_pos]     = 1'b1;
                        wr_data               = rd_data & ~bit_mask;
                        wr_en                 = (cmd_reg == CMD_ALLOC);
                    end
                    else if (drow_reg == last_row)
                    begin
                        rsp_next.status       = ST_NONE_FREE;
                        rsp_next.result_index = idx_reg;
                        rsp_next.was_free     = 1'b0;
                        done_next             = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                rd_addr = idx_row;
            end
            S_UPDATE:
            begin
                rd_addr           = idx_row;
                wr_addr           = idx_row;
                bit_mask[idx_bit] = 1'b1;
                wr_data           = (cmd_reg == CMD_RELEASE) ? (rd_data | bit_mask)
                                                              : (rd_data & ~bit_mask);
                wr_en                 = 1'b1;
                rsp_next.status       = ST_OK;
                rsp_next.result_index = idx_reg;
                rsp_next.was_free     = rd_data[idx_bit];
                done_next             = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        sel_reg  <= sel_next;
        idx_reg  <= idx_next;
        drow_reg <= drow_next;
        rsp_reg  <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

    // a response beat never overlaps a request in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response beat while busy");

    // every request either starts work or is answered at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted request dropped");

    // the row under evaluation never runs past the map
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> (drow_reg <= last_row))
        else $error("scan row past end of map");

    // a full map reports no free bit
    a_none_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == ST_NONE_FREE) |-> !response.was_free)
        else $error("none-free response with free bit");

    // allocation writes back only after a row with a free bit was found
    a_alloc_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_SCAN) |-> (pend_reg && ffs_found && cmd_reg == CMD_ALLOC))
        else $error("scan write without a found free bit");

endmodule
